// ===== rtl/modbus_rtu_register_slave_assert.svh =====
// assertion macros used by the top-level rtl file of the modbus rtu register slave
// no dependencies; include with the bare file name
`ifndef MODBUS_RTU_REGISTER_SLAVE_ASSERT_SVH
`define MODBUS_RTU_REGISTER_SLAVE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define MRRS_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked while out of reset
`define MRRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/mrrs_pkg.sv =====
// types, constants and functions of the modbus rtu register slave
// no dependencies; used by controller, datapath and top level
package mrrs_pkg;

    localparam int FRAME_LENGTH   = 8;
    localparam int MAP_TABLE_SIZE = 28;
    localparam int MAP_IDX_W      = 5;

    localparam logic [7:0]  FUNC_READ      = 8'h03;
    localparam logic [7:0]  FUNC_WRITE     = 8'h06;
    localparam logic [7:0]  EXC_FLAG       = 8'h80;
    localparam logic [7:0]  EXC_BAD_ADDR   = 8'h02;
    localparam logic [7:0]  EXC_BAD_VALUE  = 8'h03;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;

    // register map: address, reset value, writable
    localparam logic [15:0] MAP_ADDR [MAP_TABLE_SIZE] = '{
        16'd20101, 16'd20102, 16'd20103, 16'd20104, 16'd20108, 16'd20109, 16'd20111,
        16'd20112, 16'd20113, 16'd20118, 16'd20119, 16'd10103, 16'd10104, 16'd10105,
        16'd10107, 16'd20125, 16'd20127, 16'd20128, 16'd20132, 16'd20142, 16'd20143,
        16'd20144, 16'd15205, 16'd15206, 16'd15207, 16'd15208, 16'd25212, 16'd25274
    };
    localparam logic [15:0] MAP_INIT [MAP_TABLE_SIZE] = '{
        16'd0, 16'd2300, 16'd5000, 16'd0, 16'd0, 16'd1, 16'd0,
        16'd0, 16'd100, 16'd270, 16'd270, 16'd270, 16'd282, 16'd170,
        16'd300, 16'd600, 16'd170, 16'd300, 16'd600, 16'd0, 16'd0,
        16'd0, 16'd2200, 16'd265, 16'd150, 16'd500, 16'd800, 16'd15
    };
    localparam logic [MAP_TABLE_SIZE-1:0] MAP_WRITABLE = 28'h03F_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRC,
        ST_VERIFY,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_CRC,
        OP_DROP,
        OP_CLEAR,
        OP_DECODE,
        OP_SCAN,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic fill_last;
        logic crc_last;
        logic frame_ok;
        logic addr_ok;
        logic need_scan;
        logic scan_miss;
        logic scan_last;
        logic emit_final;
        logic emit_stall;
        logic [3:0] fill;
    } dp_status_t;

    typedef struct packed {
        logic                 hit;
        logic                 writable;
        logic [MAP_IDX_W-1:0] idx;
    } lookup_t;

    // one byte of crc-16, reflected polynomial
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // first map entry below used whose address matches
    function automatic lookup_t map_lookup(input logic [15:0] addr, input int used);
        lookup_t r;
        r = '0;
        for (int i = MAP_TABLE_SIZE - 1; i >= 0; i--) begin
            if (i < used && MAP_ADDR[i] == addr) begin
                r.hit      = 1'b1;
                r.writable = MAP_WRITABLE[i];
                r.idx      = MAP_IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/mrrs_ctrl.sv =====
// controller state machine of the modbus rtu register slave
// depends on mrrs_pkg; drives datapath operations from status
module mrrs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  mrrs_pkg::dp_status_t status,
    output mrrs_pkg::op_t        op
);

    mrrs_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mrrs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and operation
    always_comb begin
        state_next = state_reg;
        op         = mrrs_pkg::OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            mrrs_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op = mrrs_pkg::OP_LOAD;
                    if (status.fill_last) state_next = mrrs_pkg::ST_CRC;
                end
            end
            mrrs_pkg::ST_CRC: begin
                op = mrrs_pkg::OP_CRC;
                if (status.crc_last) state_next = mrrs_pkg::ST_VERIFY;
            end
            mrrs_pkg::ST_VERIFY: begin
                if (!status.frame_ok) begin
                    op         = mrrs_pkg::OP_DROP;
                    state_next = mrrs_pkg::ST_IDLE;
                end else if (!status.addr_ok) begin
                    op         = mrrs_pkg::OP_CLEAR;
                    state_next = mrrs_pkg::ST_IDLE;
                end else begin
                    op         = mrrs_pkg::OP_DECODE;
                    state_next = status.need_scan ? mrrs_pkg::ST_SCAN : mrrs_pkg::ST_EMIT;
                end
            end
            mrrs_pkg::ST_SCAN: begin
                op = mrrs_pkg::OP_SCAN;
                if (status.scan_miss || status.scan_last) state_next = mrrs_pkg::ST_EMIT;
            end
            mrrs_pkg::ST_EMIT: begin
                op = mrrs_pkg::OP_EMIT;
                if (status.emit_final && !status.emit_stall) state_next = mrrs_pkg::ST_IDLE;
            end
            default: begin
                state_next = mrrs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/mrrs_dpath.sv =====
// datapath of the modbus rtu register slave: window, crc, register file, output
// depends on mrrs_pkg; operated by mrrs_ctrl
module mrrs_dpath #(
    parameter int USED     = 28,
    parameter int MAX_QTY  = 125
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mrrs_pkg::op_t         op,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           slave_address,
    output mrrs_pkg::dp_status_t  status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          out_tx_bytes,
    output logic [2:0]           out_byte_count,
    output logic                 out_last
);

    localparam int QW    = $clog2(MAX_QTY + 1);
    localparam int IDX_W = (USED > 1) ? $clog2(USED) : 1;

    logic [7:0]  win_reg [mrrs_pkg::FRAME_LENGTH];
    logic [3:0]  fill_reg;
    logic [2:0]  cidx_reg;
    logic [15:0] crc_reg;
    logic [15:0] regs_reg [USED];
    logic        exc_reg;
    logic [7:0]  exc_code_reg;
    logic [15:0] cur_addr_reg;
    logic [QW-1:0] remain_reg;
    logic [7:0]  pos_reg;
    logic [23:0] asm_reg;
    logic [1:0]  asm_cnt_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic [2:0]  out_cnt_reg;
    logic        out_last_reg;

    logic [7:0]  func;
    logic [15:0] start_addr;
    logic [15:0] qty;
    logic        qty_ok;
    logic        is_read;
    mrrs_pkg::lookup_t lu_cur;
    mrrs_pkg::lookup_t lu_start;
    logic [7:0]  body_len;
    logic [7:0]  tx_byte;
    logic [15:0] cur_value;
    logic        emit_final;
    logic        emit_complete;
    logic        emit_stall;
    logic        out_load;

    // frame fields
    assign func       = win_reg[1];
    assign start_addr = {win_reg[2], win_reg[3]};
    assign qty        = {win_reg[4], win_reg[5]};
    assign is_read    = (func == mrrs_pkg::FUNC_READ);
    assign qty_ok     = (qty != 16'd0) && (qty <= 16'(MAX_QTY));

    // map lookups
    assign lu_cur    = mrrs_pkg::map_lookup(cur_addr_reg, USED);
    assign lu_start  = mrrs_pkg::map_lookup(start_addr, USED);
    assign cur_value = regs_reg[lu_cur.idx[IDX_W-1:0]];

    // response body length without crc
    always_comb begin
        if (exc_reg) begin
            body_len = 8'd3;
        end else if (is_read) begin
            body_len = 8'd3 + {qty[6:0], 1'b0};
        end else begin
            body_len = 8'd6;
        end
    end

    // response byte at current position
    always_comb begin
        tx_byte = 8'h00;
        if (pos_reg == body_len) begin
            tx_byte = crc_reg[7:0];
        end else if (pos_reg == body_len + 8'd1) begin
            tx_byte = crc_reg[15:8];
        end else begin
            case (pos_reg)
                8'd0: tx_byte = win_reg[0];
                8'd1: tx_byte = exc_reg ? (func | mrrs_pkg::EXC_FLAG) : func;
                8'd2: begin
                    if (exc_reg)      tx_byte = exc_code_reg;
                    else if (is_read) tx_byte = {qty[6:0], 1'b0};
                    else              tx_byte = win_reg[2];
                end
                default: begin
                    if (is_read)           tx_byte = pos_reg[0] ? cur_value[15:8] : cur_value[7:0];
                    else if (pos_reg == 8'd3) tx_byte = win_reg[3];
                    else if (pos_reg == 8'd4) tx_byte = win_reg[4];
                    else                   tx_byte = win_reg[5];
                end
            endcase
        end
    end

    assign emit_final    = (pos_reg == body_len + 8'd1);
    assign emit_complete = (asm_cnt_reg == 2'd3) || emit_final;
    assign emit_stall    = emit_complete && out_valid_reg && !out_ready;
    assign out_load      = (op == mrrs_pkg::OP_EMIT) && emit_complete && !emit_stall;

    // status to controller
    always_comb begin
        status.fill_last  = (fill_reg == 4'd7);
        status.crc_last   = (cidx_reg == 3'd5);
        status.frame_ok   = (is_read || func == mrrs_pkg::FUNC_WRITE) &&
                            ({win_reg[7], win_reg[6]} == crc_reg);
        status.addr_ok    = (win_reg[0] == slave_address);
        status.need_scan  = is_read && qty_ok;
        status.scan_miss  = !lu_cur.hit;
        status.scan_last  = (remain_reg == QW'(1));
        status.emit_final = emit_final;
        status.emit_stall = emit_stall;
        status.fill       = fill_reg;
    end

    // output beat valid: set on a new beat, cleared when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mrrs_pkg::FRAME_LENGTH; i++) win_reg[i] <= 8'h00;
            for (int i = 0; i < USED; i++) regs_reg[i] <= mrrs_pkg::MAP_INIT[i];
            fill_reg      <= 4'd0;
            cidx_reg      <= 3'd0;
            crc_reg       <= mrrs_pkg::CRC_INIT;
            exc_reg       <= 1'b0;
            exc_code_reg  <= 8'h00;
            cur_addr_reg  <= 16'h0000;
            remain_reg    <= '0;
            pos_reg       <= 8'd0;
            asm_reg       <= 24'h0;
            asm_cnt_reg   <= 2'd0;
            out_data_reg  <= 32'h0;
            out_cnt_reg   <= 3'd0;
            out_last_reg  <= 1'b0;
        end else begin
            case (op)
                mrrs_pkg::OP_LOAD: begin
                    win_reg[fill_reg[2:0]] <= rx_byte;
                    fill_reg <= fill_reg + 4'd1;
                    crc_reg  <= mrrs_pkg::CRC_INIT;
                    cidx_reg <= 3'd0;
                end
                mrrs_pkg::OP_CRC: begin
                    crc_reg  <= mrrs_pkg::crc_byte(crc_reg, win_reg[cidx_reg]);
                    cidx_reg <= cidx_reg + 3'd1;
                end
                mrrs_pkg::OP_DROP: begin
                    for (int i = 0; i < mrrs_pkg::FRAME_LENGTH - 1; i++) begin
                        win_reg[i] <= win_reg[i+1];
                    end
                    win_reg[mrrs_pkg::FRAME_LENGTH-1] <= 8'h00;
                    fill_reg <= 4'd7;
                end
                mrrs_pkg::OP_CLEAR: begin
                    for (int i = 0; i < mrrs_pkg::FRAME_LENGTH; i++) win_reg[i] <= 8'h00;
                    fill_reg <= 4'd0;
                end
                mrrs_pkg::OP_DECODE: begin
                    crc_reg      <= mrrs_pkg::CRC_INIT;
                    pos_reg      <= 8'd0;
                    asm_reg      <= 24'h0;
                    asm_cnt_reg  <= 2'd0;
                    cur_addr_reg <= start_addr;
                    remain_reg   <= qty[QW-1:0];
                    exc_reg      <= 1'b0;
                    if (is_read) begin
                        if (!qty_ok) begin
                            exc_reg      <= 1'b1;
                            exc_code_reg <= mrrs_pkg::EXC_BAD_VALUE;
                        end
                    end else if (!lu_start.hit) begin
                        exc_reg      <= 1'b1;
                        exc_code_reg <= mrrs_pkg::EXC_BAD_ADDR;
                    end else if (!lu_start.writable) begin
                        exc_reg      <= 1'b1;
                        exc_code_reg <= mrrs_pkg::EXC_BAD_VALUE;
                    end else begin
                        regs_reg[lu_start.idx[IDX_W-1:0]] <= qty;
                    end
                end
                mrrs_pkg::OP_SCAN: begin
                    if (!lu_cur.hit) begin
                        exc_reg      <= 1'b1;
                        exc_code_reg <= mrrs_pkg::EXC_BAD_ADDR;
                    end else if (remain_reg == QW'(1)) begin
                        cur_addr_reg <= start_addr;
                    end else begin
                        cur_addr_reg <= cur_addr_reg + 16'd1;
                        remain_reg   <= remain_reg - QW'(1);
                    end
                end
                mrrs_pkg::OP_EMIT: begin
                    if (!emit_stall) begin
                        pos_reg <= pos_reg + 8'd1;
                        if (pos_reg < body_len) crc_reg <= mrrs_pkg::crc_byte(crc_reg, tx_byte);
                        // step register address after each low byte of a read
                        if (is_read && !exc_reg && pos_reg >= 8'd3 && pos_reg < body_len &&
                            !pos_reg[0]) begin
                            cur_addr_reg <= cur_addr_reg + 16'd1;
                        end
                        if (emit_complete) begin
                            out_data_reg  <= {asm_reg, tx_byte};
                            out_cnt_reg   <= {1'b0, asm_cnt_reg} + 3'd1;
                            out_last_reg  <= emit_final;
                            asm_reg       <= 24'h0;
                            asm_cnt_reg   <= 2'd0;
                        end else begin
                            asm_reg     <= {asm_reg[15:0], tx_byte};
                            asm_cnt_reg <= asm_cnt_reg + 2'd1;
                        end
                        if (emit_final) begin
                            for (int i = 0; i < mrrs_pkg::FRAME_LENGTH; i++) win_reg[i] <= 8'h00;
                            fill_reg <= 4'd0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_tx_bytes   = out_data_reg;
    assign out_byte_count = out_cnt_reg;
    assign out_last       = out_last_reg;

endmodule

// ===== rtl/modbus_rtu_register_slave.sv =====
// Modbus RTU holding-register slave: received bytes in, response beats out.
// s_ channel: one received byte per beat (s_tdata[7:0]).
// m_ channel: response beats of up to four bytes, first byte in the top
//   occupied byte; m_tdata carries tx_bytes and byte_count, m_tlast ends a frame.
// APB port: register 0 at byte address 0 holds the slave address (reset 4).
// A byte that does not complete an 8-byte window is stored, and the slave stays ready.
// The eighth byte starts a check: a byte-wide crc over the six header bytes, then a decode step.
// A valid read request then scans its register range, one address per cycle,
//   before the response is sent.
// The response leaves at one byte per cycle while the receiver does not stall,
//   and every four bytes form a beat.
// No byte is taken while a frame is checked or answered; the last beat may
//   still wait in the output register while the next byte is taken.
// A stalled receiver holds the response in place until its beat is taken.
// Reset clears the window, restores register defaults and drops any response.
module modbus_rtu_register_slave #(
    parameter int MAP_ENTRIES       = 28,
    parameter int MAX_READ_QUANTITY = 125
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] tx_bytes, [34:32] byte_count, [39:35] zero
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    `include "modbus_rtu_register_slave_assert.svh"

    localparam int USED = (MAP_ENTRIES < mrrs_pkg::MAP_TABLE_SIZE) ?
                          MAP_ENTRIES : mrrs_pkg::MAP_TABLE_SIZE;
    localparam logic [2:0] ADDR_SLAVE = 3'd0;

    logic [7:0] slave_address_reg;
    mrrs_pkg::op_t        op;
    mrrs_pkg::dp_status_t status;
    logic [31:0] tx_bytes;
    logic [2:0]  byte_count;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_address_reg <= 8'd4;
        end else if (psel && penable && pwrite && paddr == ADDR_SLAVE) begin
            slave_address_reg <= pwdata[7:0];
        end
    end
    assign prdata = (paddr == ADDR_SLAVE) ? {24'h0, slave_address_reg} : 32'h0;

    // controller
    mrrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .op       (op)
    );

    // datapath
    mrrs_dpath #(
        .USED    (USED),
        .MAX_QTY (MAX_READ_QUANTITY)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .op             (op),
        .rx_byte        (s_tdata),
        .slave_address  (slave_address_reg),
        .status         (status),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_tx_bytes   (tx_bytes),
        .out_byte_count (byte_count),
        .out_last       (m_tlast)
    );

    assign m_tdata = {5'b0, byte_count, tx_bytes};

    // checks
    `MRRS_ASSERT_IMPLY(a_beat_count, aclk, aresetn, m_tvalid,
        (byte_count != 3'd0) && (byte_count <= 3'd4))
    `MRRS_ASSERT_IMPLY(a_fill_range, aclk, aresetn, 1'b1, status.fill <= 4'd8)
    `MRRS_ASSERT_IMPLY(a_take_room, aclk, aresetn, s_tvalid && s_tready, status.fill < 4'd8)
    `MRRS_ASSERT_NEXT(a_frame_check, aclk, aresetn,
        s_tvalid && s_tready && status.fill_last, !s_tready)

endmodule

// ===== tb/modbus_rtu_register_slave_checker.sv =====
// response checker for the modbus rtu register slave: watches both streams,
// predicts response beats from accepted bytes and compares them; uses mrrs_pkg
`timescale 1ns / 100ps

module modbus_rtu_register_slave_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending_beats
);

    localparam logic [2:0] ADDR_SLAVE = 3'd0;

    typedef struct packed {
        logic [31:0] tx_bytes;
        logic [2:0]  byte_count;
        logic        last;
    } beat_t;

    beat_t       beat_q[$];
    logic [7:0]  my_addr;
    logic [7:0]  win [8];
    int          fill;
    logic [15:0] regs [mrrs_pkg::MAP_TABLE_SIZE];

    assign pending_beats = beat_q.size();

    function automatic logic [15:0] crc16(input logic [7:0] b[$]);
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (b[i]) begin
            c = c ^ {8'h00, b[i]};
            for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    function automatic int find_reg(input logic [15:0] a);
        for (int i = 0; i < mrrs_pkg::MAP_TABLE_SIZE; i++)
            if (mrrs_pkg::MAP_ADDR[i] == a) return i;
        return -1;
    endfunction

    // shift one byte in, answer a complete frame
    task automatic take_byte(input logic [7:0] b);
        logic [7:0]  rsp[$];
        logic [7:0]  hdr[$];
        logic [15:0] start, qty, c;
        int          e, pos, n;
        beat_t       bt;
        if (fill >= 8) fill = 0;
        win[fill] = b;
        fill++;
        if (fill < 8) return;
        hdr = '{win[0], win[1], win[2], win[3], win[4], win[5]};
        if ((win[1] != mrrs_pkg::FUNC_READ && win[1] != mrrs_pkg::FUNC_WRITE) ||
                {win[7], win[6]} != crc16(hdr)) begin
            for (int i = 0; i < 7; i++) win[i] = win[i+1];
            win[7] = 0;
            fill = 7;
            return;
        end
        fill = 0;
        if (win[0] != my_addr) return;
        start = {win[2], win[3]};
        qty = {win[4], win[5]};
        rsp = '{win[0], win[1]};
        if (win[1] == mrrs_pkg::FUNC_READ) begin
            if (qty == 0 || qty > 125) begin
                rsp[1] = mrrs_pkg::FUNC_READ | mrrs_pkg::EXC_FLAG;
                rsp = {rsp, mrrs_pkg::EXC_BAD_VALUE};
            end else begin
                rsp = {rsp, 8'(qty * 2)};
                for (int i = 0; i < qty; i++) begin
                    e = find_reg(16'(start + i));
                    if (e < 0) begin
                        rsp = '{win[0], mrrs_pkg::FUNC_READ | mrrs_pkg::EXC_FLAG,
                                mrrs_pkg::EXC_BAD_ADDR};
                        break;
                    end
                    rsp = {rsp, regs[e][15:8], regs[e][7:0]};
                end
            end
        end else begin
            e = find_reg(start);
            if (e < 0) begin
                rsp[1] = mrrs_pkg::FUNC_WRITE | mrrs_pkg::EXC_FLAG;
                rsp = {rsp, mrrs_pkg::EXC_BAD_ADDR};
            end else if (!mrrs_pkg::MAP_WRITABLE[e]) begin
                rsp[1] = mrrs_pkg::FUNC_WRITE | mrrs_pkg::EXC_FLAG;
                rsp = {rsp, mrrs_pkg::EXC_BAD_VALUE};
            end else begin
                regs[e] = qty;
                rsp = {rsp, win[2], win[3], win[4], win[5]};
            end
        end
        c = crc16(rsp);
        rsp = {rsp, c[7:0], c[15:8]};
        for (pos = 0; pos < rsp.size(); pos += 4) begin
            n = rsp.size() - pos;
            if (n > 4) n = 4;
            bt = '0;
            for (int i = 0; i < n; i++) bt.tx_bytes = (bt.tx_bytes << 8) | rsp[pos+i];
            bt.byte_count = 3'(n);
            bt.last = (pos + n >= rsp.size());
            beat_q = {beat_q, bt};
        end
    endtask

    always @(posedge aclk) begin
        beat_t want;
        if (!aresetn) begin
            my_addr = 8'd4;
            fill = 0;
            foreach (win[i]) win[i] = 0;
            foreach (regs[i]) regs[i] = mrrs_pkg::MAP_INIT[i];
            beat_q.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready && paddr == ADDR_SLAVE)
                my_addr = pwdata[7:0];
            // response beats
            if (m_tvalid && m_tready) begin
                if (beat_q.size() == 0) begin
                    $display("%0t: unexpected beat %h last %b", $time, m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = beat_q.pop_front();
                    if (m_tdata[31:0] !== want.tx_bytes || m_tdata[34:32] !== want.byte_count
                            || m_tdata[39:35] !== 5'd0 || m_tlast !== want.last) begin
                        $display("%0t: expected bytes %h count %0d last %b, got %h %0d %b",
                            $time, want.tx_bytes, want.byte_count, want.last,
                            m_tdata[31:0], m_tdata[34:32], m_tlast);
                        fail_count++;
                    end
                end
            end
            // received bytes
            if (s_tvalid && s_tready) take_byte(s_tdata);
        end
    end
endmodule

// ===== tb/tb_modbus_rtu_register_slave.sv =====
// testbench top for the modbus rtu register slave: clock, reset, apb writes,
// request byte stimulus and verdict; uses mrrs_pkg and the response checker
`timescale 1ns / 100ps

module tb_modbus_rtu_register_slave;

    localparam logic [2:0] ADDR_SLAVE = 3'd0;

    logic        aclk = 0, aresetn = 0;
    logic        s_tvalid = 0, s_tready;
    logic [7:0]  s_tdata = 0;
    logic        m_tvalid, m_tready = 0, m_tlast;
    logic [39:0] m_tdata;
    logic        psel = 0, penable = 0, pwrite = 0, pready;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0, prdata;
    int          fail_count, pending_beats;
    logic [7:0]  cur_addr;

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    modbus_rtu_register_slave dut (.*);
    modbus_rtu_register_slave_checker u_chk (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // receiver stalls: idle gaps of random length
    always begin
        int g;
        g = gap_len();
        @(negedge aclk);
        if (g == 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b0;
            repeat (g - 1) @(negedge aclk);
        end
    end

    // one byte beat; ready is stable between edges, so it is sampled at the falling edge
    task automatic send_byte(input logic [7:0] b);
        int   g;
        logic ok;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        ok = s_tready;
        @(negedge aclk);
        while (!ok) begin
            ok = s_tready;
            @(negedge aclk);
        end
    endtask

    task automatic send_frame(input logic [7:0] a, input logic [7:0] f,
            input logic [15:0] s, input logic [15:0] q, input bit corrupt);
        logic [15:0] c;
        logic [7:0]  hb[6];
        hb = '{a, f, s[15:8], s[7:0], q[15:8], q[7:0]};
        c = 16'hFFFF;
        foreach (hb[i]) begin
            c = c ^ {8'h00, hb[i]};
            for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        if (corrupt) c = c ^ (16'd1 << $urandom_range(0, 15));
        foreach (hb[i]) send_byte(hb[i]);
        send_byte(c[7:0]);
        send_byte(c[15:8]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_beats != 0) @(negedge aclk);
        repeat (450) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [7:0] v);
        psel <= 1; pwrite <= 1; paddr <= ADDR_SLAVE; pwdata <= {24'd0, v};
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        cur_addr = v;
    endtask

    function automatic logic [15:0] map_addr_any();
        return mrrs_pkg::MAP_ADDR[$urandom_range(0, mrrs_pkg::MAP_TABLE_SIZE - 1)];
    endfunction

    initial begin
        int r;
        logic [15:0] s;
        logic [7:0]  addr_list [4];
        addr_list = '{8'd1, 8'd247, 8'd0, 8'd255};
        cur_addr = 8'd4;
        repeat (4) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: reads, writes, exceptions, wrong address, bad crc, junk
        send_frame(cur_addr, mrrs_pkg::FUNC_READ, 16'd20101, 16'd4, 0);
        send_frame(cur_addr, mrrs_pkg::FUNC_READ, 16'd20101, 16'd0, 0);
        send_frame(cur_addr, mrrs_pkg::FUNC_READ, 16'd20101, 16'd126, 0);
        send_frame(cur_addr, mrrs_pkg::FUNC_READ, 16'hFFFF, 16'd2, 0);
        send_frame(cur_addr, mrrs_pkg::FUNC_WRITE, 16'd20102, 16'hFFFF, 0);
        send_frame(cur_addr, mrrs_pkg::FUNC_WRITE, 16'd15205, 16'd1, 0);
        send_frame(cur_addr, mrrs_pkg::FUNC_WRITE, 16'd0, 16'd1, 0);
        send_frame(8'd9, mrrs_pkg::FUNC_READ, 16'd20101, 16'd1, 0);
        send_frame(cur_addr, mrrs_pkg::FUNC_READ, 16'd20101, 16'd1, 1);
        send_byte(8'h00);
        send_frame(cur_addr, mrrs_pkg::FUNC_READ, 16'd15205, 16'd4, 0);
        send_frame(cur_addr, mrrs_pkg::FUNC_READ, 16'd20102, 16'd1, 0);
        drain();

        // address extremes, including zero and the top value
        foreach (addr_list[i]) begin
            apb_write(addr_list[i]);
            if (i % 2 == 0)
                send_frame(cur_addr, mrrs_pkg::FUNC_READ, 16'd20101, 16'd4, 0);
            else
                send_frame(cur_addr, mrrs_pkg::FUNC_READ, 16'd25274, 16'd125, 0);
            drain();
        end
        apb_write(8'd4);

        // random: mostly well-formed frames, some broken, some noise
        for (int n = 0; n < 3; n++) begin
            if (n == 1) begin
                drain();
                apb_write(8'($urandom_range(1, 247)));
            end
            r = $urandom_range(0, 99);
            s = map_addr_any();
            if (r < 40)
                send_frame($urandom_range(0, 7) == 0 ? 8'($urandom) : cur_addr,
                    mrrs_pkg::FUNC_READ,
                    ($urandom_range(0, 5) == 0) ? 16'($urandom) : s,
                    ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4)), 0);
            else if (r < 75)
                send_frame(cur_addr, mrrs_pkg::FUNC_WRITE,
                    ($urandom_range(0, 5) == 0) ? 16'($urandom) : s, 16'($urandom), 0);
            else if (r < 88)
                send_frame(cur_addr,
                    $urandom_range(0, 1) ? mrrs_pkg::FUNC_READ : mrrs_pkg::FUNC_WRITE, s,
                    16'd1, 1);
            else
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
        end
        drain();
        if (fail_count == 0)
            $display("tb_modbus_rtu_register_slave: clean");
        else
            $display("tb_modbus_rtu_register_slave: errors");
        $finish;
    end

    initial begin
        #20000000;
        $display("tb_modbus_rtu_register_slave: errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mrrs_pkg.sv
rtl/mrrs_ctrl.sv
rtl/mrrs_dpath.sv
rtl/modbus_rtu_register_slave.sv
tb/modbus_rtu_register_slave_checker.sv
tb/tb_modbus_rtu_register_slave.sv
